// File: src/qsfa_pkg.sv
package qsfa_pkg;

    // Datapath command word from the controller
    typedef struct packed {
        logic store_wr;    // write input word into the element store
        logic cnt_clr;     // clear element count and overflow flag
        logic init;        // push whole range, top = 0
        logic load_iv;     // load lo/hi from the stack top
        logic pop;         // top--
        logic rd_hi;       // read store at hi
        logic rd_lo;       // read store at lo
        logic take_pivot;  // pivot <= read data
        logic dec_hi;      // hi--
        logic inc_lo;      // lo++
        logic wr_lo_data;  // store[lo] <= read data, lo++
        logic wr_hi_data;  // store[hi] <= read data, hi--
        logic wr_pivot;    // store[lo] <= pivot
        logic push;        // push the two parts; when the stack is full, keep only the left one
        logic out_adv;     // output index++
        logic out_clr;     // output index <= 0
    } qsfa_cmd_t;

    // Datapath status toward the controller
    typedef struct packed {
        logic lo_lt_hi;    // lo < hi
        logic top_neg;     // stack empty
        logic ge_pivot;    // read data >= pivot
        logic le_pivot;    // read data <= pivot
        logic out_last;    // output index is count-1
        logic cnt_zero;    // element count is zero
    } qsfa_sts_t;

endpackage

// File: src/quicksort_float_array_top.sv
// Collects IEEE floats (one word per cycle) until a word with tlast, then
// sorts them ascending with an in-place iterative quicksort and streams
// them out, tlast on the final one, tuser set on all if words were dropped
// beyond MAX_ITEMS. Sorting runs on one store with a single write port and a
// registered read, so each compare-move step issues a read and then acts on
// the read data; input is not accepted while a set is being sorted or emitted.
module quicksort_float_array_top #(
    parameter int MAX_ITEMS   = 64,
    parameter int STACK_DEPTH = 8,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_WIDTH-1:0] s_tdata,   // value
    input  logic                  s_tlast,   // last
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_WIDTH-1:0] m_tdata,   // sorted_value
    output logic                  m_tlast,   // final_res
    output logic                  m_tuser    // dropped
);

    qsfa_pkg::qsfa_cmd_t   cmd;
    qsfa_pkg::qsfa_sts_t   sts;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  overflow, out_load, in_fire;
    logic                  valid_reg, valid_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic                  last_reg, user_reg;

    assign in_fire = s_tvalid && s_tready;

    qsfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .out_busy  (valid_reg),
        .in_ready  (s_tready),
        .out_load  (out_load),
        .cmd       (cmd),
        .sts       (sts)
    );

    qsfa_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_value (s_tdata),
        .rd_data  (rd_data),
        .overflow (overflow)
    );

    // Output register
    always_comb
    begin
        valid_next = valid_reg;
        if (m_tready)
            valid_next = 1'b0;
        if (out_load)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            data_reg <= rd_data;
            last_reg <= sts.out_last;
            user_reg <= overflow;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

// File: src/qsfa_ram.sv
module qsfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/qsfa_datapath.sv
module qsfa_datapath #(
    parameter int MAX_ITEMS   = 64,
    parameter int STACK_DEPTH = 8,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qsfa_pkg::qsfa_cmd_t   cmd,
    output qsfa_pkg::qsfa_sts_t   sts,
    input  logic [DATA_WIDTH-1:0] in_value,
    output logic [DATA_WIDTH-1:0] rd_data,
    output logic                  overflow
);

    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int SW   = $clog2(STACK_DEPTH);
    localparam int TW   = SW + 1;
    localparam int EXPB = (DATA_WIDTH == 64) ? 11 : 8;
    localparam int MANB = DATA_WIDTH - 1 - EXPB;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [TW-1:0] top_reg, top_next;
    logic [CW-1:0] oidx_reg, oidx_next;
    logic [DATA_WIDTH-1:0] pivot_reg, pivot_next;
    logic [CW-1:0] sb_reg [STACK_DEPTH];
    logic [CW-1:0] se_reg [STACK_DEPTH];

    logic                  we;
    logic [AW-1:0]         waddr, raddr;
    logic [DATA_WIDTH-1:0] wdata;

    qsfa_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ITEMS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // Store port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = count_reg[AW-1:0];
        wdata = in_value;
        if (cmd.store_wr && (count_reg < CW'(MAX_ITEMS)))
        begin
            we = 1'b1;
        end
        else if (cmd.wr_lo_data)
        begin
            we    = 1'b1;
            waddr = lo_reg[AW-1:0];
            wdata = rd_data;
        end
        else if (cmd.wr_hi_data)
        begin
            we    = 1'b1;
            waddr = hi_reg[AW-1:0];
            wdata = rd_data;
        end
        else if (cmd.wr_pivot)
        begin
            we    = 1'b1;
            waddr = lo_reg[AW-1:0];
            wdata = pivot_reg;
        end
        if (cmd.rd_hi)
        begin
            raddr = hi_reg[AW-1:0];
        end
        else if (cmd.rd_lo)
        begin
            raddr = lo_reg[AW-1:0];
        end
        else
        begin
            raddr = oidx_reg[AW-1:0];
        end
    end

    // Float compare: sign-magnitude order, NaN compares false
    logic [DATA_WIDTH-2:0] mag_a, mag_p;
    logic                  nan_a, nan_p, key_ge, key_le;
    localparam logic [DATA_WIDTH-2:0] INFMAG = {{EXPB{1'b1}}, {MANB{1'b0}}};

    always_comb
    begin
        mag_a = rd_data[DATA_WIDTH-2:0];
        mag_p = pivot_reg[DATA_WIDTH-2:0];
        nan_a = mag_a > INFMAG;
        nan_p = mag_p > INFMAG;
        case ({rd_data[DATA_WIDTH-1], pivot_reg[DATA_WIDTH-1]})
            2'b00:   key_ge = mag_a >= mag_p;
            2'b11:   key_ge = mag_a <= mag_p;
            2'b01:   key_ge = 1'b1;
            default: key_ge = (mag_a == '0) && (mag_p == '0);
        endcase
        case ({rd_data[DATA_WIDTH-1], pivot_reg[DATA_WIDTH-1]})
            2'b00:   key_le = mag_a <= mag_p;
            2'b11:   key_le = mag_a >= mag_p;
            2'b10:   key_le = 1'b1;
            default: key_le = (mag_a == '0) && (mag_p == '0);
        endcase
        sts.ge_pivot = key_ge && !nan_a && !nan_p;
        sts.le_pivot = key_le && !nan_a && !nan_p;
        // an empty interval starting at 0 leaves hi at all ones (-1)
        sts.lo_lt_hi = (lo_reg < hi_reg) && (hi_reg != '1);
        sts.top_neg  = top_reg[TW-1];
        sts.out_last = (oidx_reg + CW'(1)) == count_reg;
        sts.cnt_zero = count_reg == '0;
    end

    assign overflow = ovf_reg;

    // Index, pointer and pivot updates
    logic [SW-1:0] tp;
    logic [CW-1:0] ne, nb, len_new, len_old;
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        top_next   = top_reg;
        oidx_next  = oidx_reg;
        pivot_next = pivot_reg;
        tp         = top_reg[SW-1:0];
        nb         = lo_reg + CW'(1);
        ne         = se_reg[tp];
        len_new    = ne - nb;
        len_old    = lo_reg - sb_reg[tp];
        if (cmd.store_wr)
        begin
            if (count_reg < CW'(MAX_ITEMS))
                count_next = count_reg + CW'(1);
            else
                ovf_next = 1'b1;
        end
        if (cmd.cnt_clr)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        if (cmd.init)
            top_next = '0;
        if (cmd.load_iv)
        begin
            lo_next = sb_reg[tp];
            hi_next = se_reg[tp] - CW'(1);
        end
        if (cmd.pop)
            top_next = top_reg - TW'(1);
        if (cmd.take_pivot)
            pivot_next = rd_data;
        if (cmd.dec_hi || cmd.wr_hi_data)
            hi_next = hi_reg - CW'(1);
        if (cmd.inc_lo || cmd.wr_lo_data)
            lo_next = lo_reg + CW'(1);
        if (cmd.push && (int'(tp) + 1 < STACK_DEPTH))
            top_next = top_reg + TW'(1);
        if (cmd.out_clr)
            oidx_next = '0;
        if (cmd.out_adv)
            oidx_next = oidx_reg + CW'(1);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            top_reg   <= '1;
            oidx_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            top_reg   <= top_next;
            oidx_reg  <= oidx_next;
        end
    end

    // Payload registers and interval stack
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        pivot_reg <= pivot_next;
        if (cmd.init)
        begin
            sb_reg[0] <= '0;
            se_reg[0] <= count_reg;
        end
        if (cmd.push)
        begin
            if (int'(tp) + 1 >= STACK_DEPTH)
            begin
                se_reg[tp] <= lo_reg;
            end
            else if (len_new > len_old)
            begin
                sb_reg[tp + SW'(1)] <= sb_reg[tp];
                se_reg[tp + SW'(1)] <= lo_reg;
                sb_reg[tp]          <= nb;
            end
            else
            begin
                sb_reg[tp + SW'(1)] <= nb;
                se_reg[tp + SW'(1)] <= ne;
                se_reg[tp]          <= lo_reg;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("element count beyond capacity");
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == CW'(MAX_ITEMS))
        else $error("overflow set while store not full");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.wr_lo_data, cmd.wr_hi_data, cmd.wr_pivot, cmd.store_wr}) <= 1)
        else $error("store write conflict");
`endif

endmodule

// File: src/qsfa_ctrl.sv
module qsfa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                in_last,
    input  logic                out_ready,
    input  logic                out_busy,
    output logic                in_ready,
    output logic                out_load,
    output qsfa_pkg::qsfa_cmd_t cmd,
    input  qsfa_pkg::qsfa_sts_t sts
);

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_POPCHK = 4'd2;
    localparam logic [3:0] S_PIVRD  = 4'd3;
    localparam logic [3:0] S_PIVTK  = 4'd4;
    localparam logic [3:0] S_HIRD   = 4'd5;
    localparam logic [3:0] S_HICHK  = 4'd6;
    localparam logic [3:0] S_LORD   = 4'd7;
    localparam logic [3:0] S_LOCHK  = 4'd8;
    localparam logic [3:0] S_PLACE  = 4'd9;
    localparam logic [3:0] S_ORD    = 4'd10;
    localparam logic [3:0] S_OWAIT  = 4'd11;
    localparam logic [3:0] S_OPUT   = 4'd12;

    logic [3:0] state_reg, state_next;

    assign in_ready = state_reg == S_LOAD;

    // Load, sort and output sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.store_wr = in_fire;
                if (in_fire && in_last)
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_POPCHK;
            end
            S_POPCHK:
            begin
                if (sts.top_neg)
                begin
                    cmd.out_clr = 1'b1;
                    state_next  = S_ORD;
                end
                else
                begin
                    cmd.load_iv = 1'b1;
                    state_next  = S_PIVRD;
                end
            end
            S_PIVRD:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.rd_lo  = 1'b1;
                    state_next = S_PIVTK;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPCHK;
                end
            end
            S_PIVTK:
            begin
                cmd.take_pivot = 1'b1;
                state_next     = S_HIRD;
            end
            S_HIRD:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.rd_hi  = 1'b1;
                    state_next = S_HICHK;
                end
                else
                    state_next = S_PLACE;
            end
            S_HICHK:
            begin
                if (sts.ge_pivot)
                begin
                    cmd.dec_hi = 1'b1;
                    state_next = S_HIRD;
                end
                else
                begin
                    cmd.wr_lo_data = 1'b1;
                    state_next     = S_LORD;
                end
            end
            S_LORD:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.rd_lo  = 1'b1;
                    state_next = S_LOCHK;
                end
                else
                    state_next = S_PLACE;
            end
            S_LOCHK:
            begin
                if (sts.le_pivot)
                begin
                    cmd.inc_lo = 1'b1;
                    state_next = S_LORD;
                end
                else
                begin
                    cmd.wr_hi_data = 1'b1;
                    state_next     = S_HIRD;
                end
            end
            S_PLACE:
            begin
                cmd.wr_pivot = 1'b1;
                cmd.push     = 1'b1;
                state_next   = S_POPCHK;
            end
            S_ORD:
            begin
                if (sts.cnt_zero)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_LOAD;
                end
                else
                    state_next = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (!out_busy || out_ready)
                    state_next = S_OPUT;
            end
            S_OPUT:
            begin
                out_load    = 1'b1;
                cmd.out_adv = 1'b1;
                if (sts.out_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_LOAD;
                end
                else
                    state_next = S_OWAIT;
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_LOAD)
        else $error("ready outside load");
    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_busy || out_ready))
        else $error("output overwritten");
    a_sort_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_last) |=> state_reg == S_INIT)
        else $error("last word did not start sort");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int MAX_ITEMS   = 64;
    localparam int STACK_DEPTH = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [DATA_WIDTH-1:0] fword_t;

    typedef struct packed {
        fword_t value;
        logic   last;
    } in_word_t;

    typedef struct packed {
        fword_t value;
        logic   final_res;
        logic   dropped;
    } out_word_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   s_tvalid = 1'b0;
    logic   s_tready;
    fword_t s_tdata = '0;
    logic   s_tlast = 1'b0;
    logic   m_tvalid;
    logic   m_tready = 1'b0;
    fword_t m_tdata;
    logic   m_tlast;
    logic   m_tuser;

    quicksort_float_array_top #(
        .MAX_ITEMS  (MAX_ITEMS),
        .STACK_DEPTH(STACK_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #6 clk = ~clk;

    in_word_t  pending_words[$];
    out_word_t sorted_expect[$];
    fword_t    set_store[MAX_ITEMS];
    int        set_count;
    logic      set_overflow;
    int        error_count;
    int        sets_done;
    int        words_out;
    int        cycle_count;
    logic      no_idle;
    logic      hold_req = 1'b0;
    logic      hold_done = 1'b0;
    int        hold_off = 0;
    logic      s_tready_q = 1'b0;

    // float compare helpers: NaN compares false
    function automatic bit is_nan_f(fword_t x);
        return x[30:23] == 8'hff && x[22:0] != 0;
    endfunction

    function automatic longint fkey(fword_t x);
        longint mag;
        mag = longint'(x[30:0]);
        return x[31] ? -mag : mag;
    endfunction

    function automatic bit fge(fword_t a, fword_t b);
        if (is_nan_f(a) || is_nan_f(b))
            return 0;
        return fkey(a) >= fkey(b);
    endfunction

    function automatic bit fle(fword_t a, fword_t b);
        if (is_nan_f(a) || is_nan_f(b))
            return 0;
        return fkey(a) <= fkey(b);
    endfunction

    // in-place iterative quicksort over set_store[0..n-1]
    task automatic quicksort_set(int n);
        int     beg_stk[STACK_DEPTH];
        int     end_stk[STACK_DEPTH];
        int     top;
        int     lo;
        int     hi;
        int     t;
        fword_t pivot;
        top = 0;
        beg_stk[0] = 0;
        end_stk[0] = n;
        while (top >= 0)
        begin
            lo = beg_stk[top];
            hi = end_stk[top] - 1;
            if (lo < hi)
            begin
                pivot = set_store[lo];
                while (lo < hi)
                begin
                    while (lo < hi && fge(set_store[hi], pivot))
                        hi--;
                    if (lo < hi)
                        set_store[lo++] = set_store[hi];
                    while (lo < hi && fle(set_store[lo], pivot))
                        lo++;
                    if (lo < hi)
                        set_store[hi--] = set_store[lo];
                end
                set_store[lo] = pivot;
                if (top + 1 >= STACK_DEPTH)
                begin
                    end_stk[top] = lo;
                    continue;
                end
                beg_stk[top + 1] = lo + 1;
                end_stk[top + 1] = end_stk[top];
                end_stk[top] = lo;
                top++;
                // smaller interval goes on top
                if (end_stk[top] - beg_stk[top] > end_stk[top - 1] - beg_stk[top - 1])
                begin
                    t = beg_stk[top];
                    beg_stk[top] = beg_stk[top - 1];
                    beg_stk[top - 1] = t;
                    t = end_stk[top];
                    end_stk[top] = end_stk[top - 1];
                    end_stk[top - 1] = t;
                end
            end
            else
            begin
                top--;
            end
        end
    endtask

    // collect one accepted word; on last, sort and queue the expected output
    task automatic predict_sorted(in_word_t w);
        out_word_t r;
        if (set_count < MAX_ITEMS)
            set_store[set_count++] = w.value;
        else
            set_overflow = 1'b1;
        if (w.last)
        begin
            quicksort_set(set_count);
            for (int k = 0; k < set_count; k++)
            begin
                r.value = set_store[k];
                r.final_res = (k == set_count - 1);
                r.dropped = set_overflow;
                sorted_expect.push_back(r);
            end
            set_count = 0;
            set_overflow = 1'b0;
        end
    endtask

    function automatic fword_t rand_float();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return {1'($urandom), 31'h0};
            1: return {1'($urandom), 8'hff, 23'h0};
            2: return {1'($urandom), 8'h00, 23'($urandom)};
            3: return {1'($urandom), 8'h7f, 20'h0, 3'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic add_word(fword_t v, logic l);
        in_word_t w;
        w.value = v;
        w.last = l;
        pending_words.push_back(w);
    endtask

    // random set of n values, optionally with NaNs mixed in
    task automatic add_set(int n, bit with_nan);
        fword_t v;
        for (int i = 0; i < n; i++)
        begin
            v = rand_float();
            if (with_nan && $urandom_range(0, 3) == 0)
                v = {1'($urandom), 8'hff, 23'($urandom_range(1, 23'h7fffff))};
            add_word(v, i == n - 1);
        end
    endtask

    // driver: present words at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready_q)
            begin
                if (pending_words.size() > 0
                    && (no_idle || $urandom_range(0, 99) >= 23))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_words[0].value;
                    s_tlast  <= pending_words[0].last;
                    void'(pending_words.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // accept flag sampled at the rising edge
    always @(posedge clk)
    begin
        s_tready_q <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            predict_sorted('{s_tdata, s_tlast});
    end

    // receiver: random stalls plus a counted long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_off  <= 300;
            m_tready  <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= no_idle || $urandom_range(0, 99) >= 23;
    end

    // monitor: compare against the oldest expected word
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_out <= words_out + 1;
            if (sorted_expect.size() == 0)
            begin
                $display("%0t: unexpected word value=%h last=%b user=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                error_count <= error_count + 1;
            end
            else
            begin
                e = sorted_expect.pop_front();
                if (e.value !== m_tdata || e.final_res !== m_tlast
                    || e.dropped !== m_tuser)
                begin
                    $display("%0t: mismatch exp value=%h last=%b user=%b, got %h %b %b",
                             $time, e.value, e.final_res, e.dropped,
                             m_tdata, m_tlast, m_tuser);
                    error_count <= error_count + 1;
                end
                if (m_tlast)
                    sets_done <= sets_done + 1;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout with %0d words still expected", sorted_expect.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int n;
        int total;
        error_count = 0;
        sets_done = 0;
        words_out = 0;
        cycle_count = 0;
        set_count = 0;
        set_overflow = 1'b0;
        no_idle = 1'b0;

        // directed: single word, extremes, signed zeros, infinities, denormals
        add_word(32'h3f80_0000, 1'b1);
        add_word(32'h0000_0000, 1'b0);
        add_word(32'h8000_0000, 1'b0);
        add_word(32'h7f80_0000, 1'b0);
        add_word(32'hff80_0000, 1'b0);
        add_word(32'h0000_0001, 1'b0);
        add_word(32'h8000_0001, 1'b0);
        add_word(32'h7f7f_ffff, 1'b0);
        add_word(32'hff7f_ffff, 1'b0);
        add_word(32'h3f80_0000, 1'b0);
        add_word(32'h3f80_0000, 1'b0);
        add_word(32'h7fc0_0000, 1'b0);
        add_word(32'hffff_ffff, 1'b0);
        add_word(32'h0000_0000, 1'b1);
        // two already sorted sets, one positive and one negative
        for (int i = 0; i < 5; i++)
            add_word(32'h4000_0000 + i, i == 4);
        for (int i = 0; i < 5; i++)
            add_word(32'hc000_0000 - i, i == 4);

        @(negedge clk);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // random sets, mostly small
        total = 0;
        while (total < 60)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            add_set(n, $urandom_range(0, 4) == 0);
            total += n;
        end
        wait (pending_words.size() == 0);

        // full store plus overflow (last word dropped too) under a long hold-off
        no_idle = 1'b1;
        hold_req = 1'b1;
        add_set(MAX_ITEMS + 3, 1'b0);
        wait (pending_words.size() == 0);
        no_idle = 1'b0;
        add_set(3, 1'b0);
        add_set(2, 1'b1);

        wait (pending_words.size() == 0 && !s_tvalid);
        wait (sorted_expect.size() == 0);
        repeat (200) @(posedge clk);

        $display("sets sorted: %0d, words checked: %0d, incl. overflow and NaN sets",
                 sets_done, words_out);
        if (error_count == 0 && sorted_expect.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
